/* hw/rtl/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg: shared definitions for the shifting array table
// Command and status codes, field widths, defaults and the per-cell control
// bundle that the top level hands to every cell in the row.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_EDIT   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // Operation applied to the whole row in the cycle a command is accepted.
  typedef struct packed {
    logic ins;   // open a slot at the target and write the value there
    logic del;   // close the slot at the target
    logic wr;    // overwrite the target entry
    logic rd;    // present the target entry on the read bus
    logic find;  // compare every held entry with the value
  } cell_ctrl_t;

endpackage

/* hw/rtl/sat_cell.sv */
// ----------------------------------------------------------------------------
// sat_cell: one entry of the shifting array table
// Holds one word, takes its left or right neighbor's word on insert or
// delete, and reports a match and a gated read of its own word.
// ----------------------------------------------------------------------------
module sat_cell
  import sat_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]    tgt,
  input  logic [$clog2(DEPTH+1)-1:0]    count,
  input  logic [DATA_WIDTH-1:0]         value,
  input  logic [DATA_WIDTH-1:0]         left,
  input  logic [DATA_WIDTH-1:0]         right,
  output logic [DATA_WIDTH-1:0]         data,
  output logic                          match,
  output logic [DATA_WIDTH-1:0]         rd_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [DATA_WIDTH-1:0] data_next;
  logic                  at_tgt;
  logic                  past_tgt;

  assign at_tgt   = (MY_IDX == tgt);
  assign past_tgt = (MY_IDX >= tgt);

  always_comb begin
    data_next = data;
    if (ctrl.ins && past_tgt) begin
      data_next = at_tgt ? value : left;
    end else if (ctrl.del && past_tgt) begin
      data_next = right;
    end else if (ctrl.wr && at_tgt) begin
      data_next = value;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Entries at or above the count are stale and must not report a hit.
  assign match   = ctrl.find && (MY_IDX < count) && (data == value);
  assign rd_data = (ctrl.rd && at_tgt) ? data : '0;

endmodule

/* hw/rtl/shifting_array_table_unit.sv */
// ----------------------------------------------------------------------------
// shifting_array_table_unit: fixed-capacity ordered array of signed words
// Append, insert, edit, delete, get and find commands over a row of cells.
// ----------------------------------------------------------------------------
// Each accepted command yields exactly one result transaction. The block
// takes one command per clock cycle unless a pending result is not drained:
// the row of DEPTH cells shifts the entries at and past the target for an
// insert or delete and compares every entry for a find in the cycle the
// command is accepted, and the result sits in an output register while the
// next command is taken. Throughput is therefore one registered result per
// cycle, limited only by the output register being drained. Entries are
// undefined after reset; only entries below the element count are ever read.
// ----------------------------------------------------------------------------
module shifting_array_table_unit
  import sat_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cmd[2:0], position[6:3], value[38:7], zero fill[39]
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status[1:0], read_data[33:2], found[34], element_count[39:35],
  // is_full[40], zero fill[47:41]
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int RD_CELLS = (DEPTH < 16) ? DEPTH : 16;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CMD_W-1:0]          in_cmd;
  logic [POS_W-1:0]          in_pos;
  logic signed [VALUE_W-1:0] in_value;
  logic [DATA_WIDTH-1:0]     word;

  logic                      accept;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      full;
  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             count_x;
  logic                      pos_lt;
  logic                      pos_le;
  cell_ctrl_t                op;
  cell_ctrl_t                ctrl;
  logic [CW-1:0]             tgt;
  status_t                   status;

  logic [DATA_WIDTH-1:0]     cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0]     cell_rd    [DEPTH];
  logic                      cell_match [DEPTH];
  logic [DATA_WIDTH-1:0]     rd_word;
  logic                      any_match;

  logic [STATUS_W-1:0]       out_status;
  logic [VALUE_W-1:0]        out_rdata;
  logic                      out_found;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_full;

  assign in_cmd   = s_tdata[2:0];
  assign in_pos   = s_tdata[6:3];
  assign in_value = s_tdata[38:7];
  assign word     = DATA_WIDTH'(in_value);

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full    = (count == FULL_COUNT);
  assign pos_x   = XW'(in_pos);
  assign count_x = XW'(count);
  assign pos_lt  = (pos_x < count_x);
  assign pos_le  = (pos_x <= count_x);

  // Append is an insert at the current count.
  assign tgt = (in_cmd == CMD_APPEND) ? count : CW'(in_pos);

  always_comb begin
    op         = '0;
    status     = ST_OK;
    count_next = count;
    case (in_cmd)
      CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op.ins     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (!pos_le) begin
          status = ST_BAD_INDEX;
        end else begin
          op.ins     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_EDIT: begin
        if (pos_lt) begin
          op.wr = 1'b1;
        end else begin
          status = ST_BAD_INDEX;
        end
      end
      CMD_DELETE: begin
        if (pos_lt) begin
          op.del     = 1'b1;
          count_next = count - 1'b1;
        end else begin
          status = ST_BAD_INDEX;
        end
      end
      CMD_GET: begin
        if (pos_lt) begin
          op.rd = 1'b1;
        end else begin
          status = ST_BAD_INDEX;
        end
      end
      CMD_FIND: begin
        op.find = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ctrl = accept ? op : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = word;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    sat_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .tgt     (tgt),
      .count   (count),
      .value   (word),
      .left    (left_data),
      .right   (right_data),
      .data    (cell_data[i]),
      .match   (cell_match[i]),
      .rd_data (cell_rd[i])
    );
  end

  // Only the first sixteen entries can be addressed by a position.
  always_comb begin
    rd_word   = '0;
    any_match = 1'b0;
    for (int i = 0; i < RD_CELLS; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
    for (int i = 0; i < DEPTH; i++) begin
      any_match = any_match | cell_match[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status;
      out_rdata  <= VALUE_W'($signed(rd_word));
      out_found  <= any_match;
      out_count  <= COUNT_W'(count_next);
      out_full   <= (count_next == FULL_COUNT);
    end
  end

  assign m_tdata = {7'd0, out_full, out_count, out_found, out_rdata, out_status};

  // The count never goes beyond the capacity of the row.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("element count exceeds capacity");

  // A successful append grows the count by exactly one.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == CMD_APPEND && !full) |=> (count == $past(count) + 1'b1))
    else $error("append did not grow the count");

  // A find leaves the count untouched.
  a_find_stable: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == CMD_FIND) |=> $stable(count))
    else $error("find changed the count");

  // A pending result's full flag agrees with the live count.
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_full == (count == FULL_COUNT)))
    else $error("full flag disagrees with count");

endmodule
